FILE: src/sdsh_pkg.sv
// Package for the SD card SPI-mode host sequencer.
// Holds payload structs, command codes, phases and card opcodes. No dependencies.
package sdsh_pkg;

	typedef enum logic [2:0] {
		CMD_XFER  = 3'd0,
		CMD_INIT  = 3'd1,
		CMD_OPENR = 3'd2,
		CMD_OPENW = 3'd3,
		CMD_CLOSE = 3'd4
	} cmd_t;

	typedef enum logic [5:0] {
		PH_IDLE   = 6'b000001,
		PH_WARM   = 6'b000010,
		PH_SEND   = 6'b000100,
		PH_R1WAIT = 6'b001000,
		PH_TOKEN  = 6'b010000,
		PH_DATA   = 6'b100000
	} phase_t;

	localparam logic [7:0] OP_IDLE  = 8'h00;
	localparam logic [7:0] OP_CSD   = 8'h09;
	localparam logic [7:0] OP_READ  = 8'h11;
	localparam logic [7:0] OP_WRITE = 8'h18;
	localparam logic [7:0] OP_APP   = 8'h37;
	localparam logic [7:0] OP_INIT  = 8'h29;

	localparam logic [7:0] BYTE_IDLE  = 8'hFF;
	localparam logic [7:0] BYTE_TOKEN = 8'hFE;
	localparam logic [7:0] BYTE_CRC   = 8'h95;
	localparam logic [7:0] CMD_MARK   = 8'h40;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_IDLE_TO  = 3'd1;
	localparam logic [2:0] ST_INIT_TO  = 3'd2;
	localparam logic [2:0] ST_NO_APP   = 3'd3;
	localparam logic [2:0] ST_CSD_FAIL = 3'd4;
	localparam logic [2:0] ST_RD_FAIL  = 3'd5;
	localparam logic [2:0] ST_WR_FAIL  = 3'd6;
	localparam logic [2:0] ST_RANGE    = 3'd7;

	typedef struct packed {
		logic [2:0]  command;
		logic [31:0] block_index;
		logic [7:0]  rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  tx_byte;
		logic        tx_valid;
		logic        chip_select_low;
		logic        slow_clock;
		logic        done_res;
		logic [2:0]  status;
		logic [21:0] card_blocks;
		logic [15:0] read_block_bytes;
		logic [15:0] write_block_bytes;
		logic        open_for_read;
		logic        open_for_write;
	} out_item_t;

endpackage

FILE: src/sd_spi_host_sequencer_unit.sv
// SD card SPI-mode host sequencer, top level.
// Uses sdsh_pkg for payload structs, phases and card opcodes.
//
// Usage: each transfer on the input channel is a request (init, open for
// read, open for write, close) or the byte received in the last SPI exchange
// (command 0). Each accepted item gives exactly one result transfer: the next
// byte to shift out with tx_valid, chip select, clock speed, and done/status
// when a request finishes, plus the card geometry and open flags.
// Timing: an accepted item is decoded combinationally from the input into
// the result register; its result is offered the cycle after acceptance.
// Throughput: one item per cycle while each result is taken, bounded by the
// sequencer update (one phase step and one CSD byte write per item). In use the rate
// is one item per SPI byte exchange.
// Reset: phase idle, counters and geometry zero, open flags clear, slow clock,
// card deselected. The CSD buffer holds garbage until the CSD read fills it.
// Stall: while the result register holds an untaken result, a new item is
// still taken if the result is leaving the same cycle; otherwise ready drops
// and the input side waits.
module sd_spi_host_sequencer_unit
	import sdsh_pkg::*;
#(
	parameter int RETRY_LIMIT  = 255,
	parameter int WARMUP_BYTES = 10
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	localparam logic [7:0] RetryLim = RETRY_LIMIT[7:0];
	localparam logic [4:0] WarmLim  = WARMUP_BYTES[4:0];

	// state
	phase_t      phase_q;
	logic [7:0]  retry_q;
	logic [4:0]  bcnt_q;
	logic [31:0] arg_q;
	logic [7:0]  op_q;
	logic [7:0]  csd_q [16];
	logic [21:0] blocks_q;
	logic [3:0]  rsh_q;
	logic [3:0]  wsh_q;
	logic [31:0] open_blk_q;
	logic        fl_rd_q;
	logic        fl_wr_q;
	logic        slow_q;
	logic        cs_q;
	logic        ovalid_q;
	out_item_t   odata_q;

	// next state
	phase_t      phase_d;
	logic [7:0]  retry_d;
	logic [4:0]  bcnt_d;
	logic [31:0] arg_d;
	logic [7:0]  op_d;
	logic [21:0] blocks_d;
	logic [3:0]  rsh_d;
	logic [3:0]  wsh_d;
	logic [31:0] open_blk_d;
	logic        fl_rd_d;
	logic        fl_wr_d;
	logic        slow_d;
	logic        cs_d;
	logic        csd_we;
	logic [7:0]  tx_d;
	logic        txv_d;
	logic        done_d;
	logic [2:0]  st_d;

	logic        take;
	logic [7:0]  rx;
	logic [7:0]  retry_inc;
	logic        retry_hit;
	logic [2:0]  fail_code;
	logic [7:0]  frame_b;
	logic [4:0]  bcnt_inc;
	logic [3:0]  sh;
	logic [63:0] shifted;
	logic [11:0] c_size;
	logic [2:0]  mult;
	logic [12:0] c_size1;
	logic [3:0]  cshift;
	logic [27:0] blocks_full;

	assign in_ready  = !ovalid_q || out_ready;
	assign take      = in_valid && in_ready;
	assign out_valid = ovalid_q;
	assign out_data  = odata_q;

	assign rx        = in_data.rx_byte;
	assign retry_inc = retry_q + 8'd1;
	assign retry_hit = retry_inc >= RetryLim;
	assign bcnt_inc  = bcnt_q + 5'd1;
	assign fail_code = (op_q == OP_CSD) ? ST_CSD_FAIL :
		(op_q == OP_READ) ? ST_RD_FAIL : ST_WR_FAIL;

	// command frame byte for the incremented count
	always_comb begin
		case (bcnt_inc)
			5'd1: frame_b = op_q | CMD_MARK;
			5'd2: frame_b = arg_q[31:24];
			5'd3: frame_b = arg_q[23:16];
			5'd4: frame_b = arg_q[15:8];
			5'd5: frame_b = arg_q[7:0];
			5'd6: frame_b = BYTE_CRC;
			default: frame_b = BYTE_IDLE;
		endcase
	end

	// byte address for opens
	assign sh      = (in_data.command == CMD_OPENW) ? wsh_q : rsh_q;
	assign shifted = {32'd0, in_data.block_index} << sh;

	// CSD v1 decode; last byte (index 15) does not feed the fields
	assign c_size      = {csd_q[6][1:0], csd_q[7], csd_q[8][7:6]};
	assign mult        = {csd_q[9][1:0], csd_q[10][7]};
	assign c_size1     = {1'b0, c_size} + 13'd1;
	assign cshift      = {1'b0, mult} + 4'd2;
	assign blocks_full = {15'd0, c_size1} << cshift;

	// sequencer step
	always_comb begin
		phase_d    = phase_q;
		retry_d    = retry_q;
		bcnt_d     = bcnt_q;
		arg_d      = arg_q;
		op_d       = op_q;
		blocks_d   = blocks_q;
		rsh_d      = rsh_q;
		wsh_d      = wsh_q;
		open_blk_d = open_blk_q;
		fl_rd_d    = fl_rd_q;
		fl_wr_d    = fl_wr_q;
		slow_d     = slow_q;
		cs_d       = cs_q;
		csd_we     = 1'b0;
		tx_d       = 8'd0;
		txv_d      = 1'b0;
		done_d     = 1'b0;
		st_d       = ST_OK;
		case (in_data.command)
			CMD_XFER: begin
				case (phase_q)
					PH_WARM: begin
						if (bcnt_q < WarmLim) begin
							bcnt_d = bcnt_inc;
							tx_d = BYTE_IDLE; txv_d = 1'b1;
						end else begin
							retry_d = 8'd0;
							op_d = OP_IDLE; arg_d = 32'd0; bcnt_d = 5'd0;
							phase_d = PH_SEND; cs_d = 1'b1;
							tx_d = BYTE_IDLE; txv_d = 1'b1;
						end
					end
					PH_SEND: begin
						if (bcnt_q < 5'd8) begin
							bcnt_d = bcnt_inc;
							tx_d = frame_b; txv_d = 1'b1;
						end else begin
							// R1 response handling per opcode
							tx_d = BYTE_IDLE;
							if (op_q == OP_IDLE) begin
								if (rx == 8'h01) begin
									slow_d = 1'b0; retry_d = 8'd0;
									op_d = OP_APP; arg_d = 32'd0; bcnt_d = 5'd0;
									txv_d = 1'b1;
								end else begin
									retry_d = retry_inc;
									if (retry_hit) begin
										phase_d = PH_IDLE; done_d = 1'b1; st_d = ST_IDLE_TO;
										tx_d = 8'd0;
									end else begin
										bcnt_d = 5'd0; txv_d = 1'b1;
									end
								end
							end else if (op_q == OP_APP) begin
								if (rx == BYTE_IDLE) begin
									phase_d = PH_IDLE; done_d = 1'b1; st_d = ST_NO_APP;
									tx_d = 8'd0;
								end else begin
									op_d = OP_INIT; arg_d = 32'd0; bcnt_d = 5'd0;
									txv_d = 1'b1;
								end
							end else if (op_q == OP_INIT) begin
								if (rx == 8'h00) begin
									retry_d = 8'd0;
									op_d = OP_CSD; arg_d = 32'd0; bcnt_d = 5'd0;
									txv_d = 1'b1;
								end else begin
									retry_d = retry_inc;
									if (retry_hit) begin
										phase_d = PH_IDLE; done_d = 1'b1; st_d = ST_INIT_TO;
										tx_d = 8'd0;
									end else begin
										op_d = OP_APP; arg_d = 32'd0; bcnt_d = 5'd0;
										txv_d = 1'b1;
									end
								end
							end else begin
								if (rx == 8'h00) begin
									retry_d = 8'd0; phase_d = PH_TOKEN; txv_d = 1'b1;
								end else begin
									retry_d = retry_inc;
									if (retry_hit) begin
										phase_d = PH_IDLE; done_d = 1'b1; st_d = fail_code;
										tx_d = 8'd0;
									end else begin
										phase_d = PH_R1WAIT; txv_d = 1'b1;
									end
								end
							end
						end
					end
					PH_R1WAIT: begin
						tx_d = BYTE_IDLE;
						if (rx == 8'h00) begin
							retry_d = 8'd0; phase_d = PH_TOKEN; txv_d = 1'b1;
						end else begin
							retry_d = retry_inc;
							if (retry_hit) begin
								phase_d = PH_IDLE; done_d = 1'b1; st_d = fail_code;
								tx_d = 8'd0;
							end else begin
								txv_d = 1'b1;
							end
						end
					end
					PH_TOKEN: begin
						if (rx == BYTE_TOKEN) begin
							if (op_q == OP_CSD) begin
								bcnt_d = 5'd0; phase_d = PH_DATA;
								tx_d = BYTE_IDLE; txv_d = 1'b1;
							end else begin
								fl_rd_d = (op_q == OP_READ);
								fl_wr_d = (op_q != OP_READ);
								phase_d = PH_IDLE; done_d = 1'b1;
							end
						end else if (rx != BYTE_IDLE) begin
							phase_d = PH_IDLE; done_d = 1'b1; st_d = fail_code;
						end else begin
							retry_d = retry_inc;
							if (retry_hit) begin
								phase_d = PH_IDLE; done_d = 1'b1; st_d = fail_code;
							end else begin
								tx_d = BYTE_IDLE; txv_d = 1'b1;
							end
						end
					end
					PH_DATA: begin
						csd_we = 1'b1;
						bcnt_d = bcnt_inc;
						if (bcnt_inc >= 5'd16) begin
							blocks_d = blocks_full[21:0];
							wsh_d = {csd_q[12][1:0], csd_q[13][7:6]};
							rsh_d = csd_q[5][3:0];
							phase_d = PH_IDLE; done_d = 1'b1;
						end else begin
							tx_d = BYTE_IDLE; txv_d = 1'b1;
						end
					end
					default: ;
				endcase
			end
			CMD_INIT: begin
				slow_d = 1'b1; cs_d = 1'b0; bcnt_d = 5'd1;
				phase_d = PH_WARM; tx_d = BYTE_IDLE; txv_d = 1'b1;
			end
			CMD_OPENR, CMD_OPENW: begin
				fl_rd_d = 1'b0; fl_wr_d = 1'b0;
				if (in_data.block_index < {10'd0, blocks_q}) begin
					open_blk_d = in_data.block_index;
					retry_d = 8'd0;
					op_d = (in_data.command == CMD_OPENW) ? OP_WRITE : OP_READ;
					arg_d = shifted[31:0]; bcnt_d = 5'd0;
					phase_d = PH_SEND; cs_d = 1'b1;
					tx_d = BYTE_IDLE; txv_d = 1'b1;
				end else begin
					phase_d = PH_IDLE; done_d = 1'b1; st_d = ST_RANGE;
				end
			end
			CMD_CLOSE: begin
				fl_rd_d = 1'b0; fl_wr_d = 1'b0;
				phase_d = PH_IDLE; done_d = 1'b1;
			end
			default: ;
		endcase
	end

	// control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			retry_q    <= 8'd0;
			bcnt_q     <= 5'd0;
			arg_q      <= 32'd0;
			op_q       <= OP_IDLE;
			blocks_q   <= 22'd0;
			rsh_q      <= 4'd0;
			wsh_q      <= 4'd0;
			open_blk_q <= 32'd0;
			fl_rd_q    <= 1'b0;
			fl_wr_q    <= 1'b0;
			slow_q     <= 1'b1;
			cs_q       <= 1'b0;
			ovalid_q   <= 1'b0;
		end else begin
			if (take) begin
				phase_q    <= phase_d;
				retry_q    <= retry_d;
				bcnt_q     <= bcnt_d;
				arg_q      <= arg_d;
				op_q       <= op_d;
				blocks_q   <= blocks_d;
				rsh_q      <= rsh_d;
				wsh_q      <= wsh_d;
				open_blk_q <= open_blk_d;
				fl_rd_q    <= fl_rd_d;
				fl_wr_q    <= fl_wr_d;
				slow_q     <= slow_d;
				cs_q       <= cs_d;
				ovalid_q   <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// CSD buffer and result register
	always_ff @(posedge clk) begin
		if (take && csd_we) begin
			csd_q[bcnt_q[3:0]] <= rx;
		end
		if (take) begin
			odata_q.tx_byte           <= tx_d;
			odata_q.tx_valid          <= txv_d;
			odata_q.chip_select_low   <= cs_d;
			odata_q.slow_clock        <= slow_d;
			odata_q.done_res          <= done_d;
			odata_q.status            <= st_d;
			odata_q.card_blocks       <= blocks_d;
			odata_q.read_block_bytes  <= 16'd1 << rsh_d;
			odata_q.write_block_bytes <= 16'd1 << wsh_d;
			odata_q.open_for_read     <= fl_rd_d;
			odata_q.open_for_write    <= fl_wr_d;
		end
	end

	// checks
	property p_hold;
		@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data);
	endproperty
	a_hold: assert property (p_hold) else $error("result changed while stalled");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		!(fl_rd_q && fl_wr_q)) else $error("open for read and write at once");

	// the counter keeps its last value until warm-up ends or an open clears it
	a_retry: assert property (@(posedge clk) disable iff (!arst_n)
		retry_q < RetryLim || phase_q == PH_IDLE || phase_q == PH_WARM)
		else $error("retry past limit");

	a_done_tx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.done_res && out_data.tx_valid))
		else $error("done with exchange request");

endmodule
